// File: sv/tfw_pkg.sv
// ----------------------------------------------------------------------------
// TCP flow firewall package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tfw_pkg;

   localparam logic [1:0] VERDICT_DROP = 2'd0;
   localparam logic [1:0] VERDICT_PASS = 2'd1;
   localparam logic [1:0] VERDICT_TX   = 2'd2;

   localparam logic [31:0] TRUSTED_NET_RESET  = 32'hAC10_7000;
   localparam logic [31:0] TRUSTED_MASK_RESET = 32'hFFFF_FF00;

   localparam logic REG_TRUSTED_NET  = 1'b0;
   localparam logic REG_TRUSTED_MASK = 1'b1;

   localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
   localparam logic [15:0] IP_MIN_FRAME   = 16'd34;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [3:0]  IHL_MIN        = 4'd5;
   localparam logic [16:0] TCP_HDR_BASE   = 17'd34;

   localparam int KEY_W = 96;

   typedef enum logic [9:0] {
      ST_INIT       = 10'b00_0000_0001,
      ST_CLEAR      = 10'b00_0000_0010,
      ST_IDLE       = 10'b00_0000_0100,
      ST_CHECK      = 10'b00_0000_1000,
      ST_LOOKUP     = 10'b00_0001_0000,
      ST_DECIDE     = 10'b00_0010_0000,
      ST_TOUCH_FWD  = 10'b00_0100_0000,
      ST_COMMIT_REV = 10'b00_1000_0000,
      ST_TOUCH_LAST = 10'b01_0000_0000,
      ST_EMIT       = 10'b10_0000_0000
   } tfw_state_type;

   typedef struct packed {
      logic       load;
      logic       go;
      logic       go_touch;
      logic       go_search;
      logic       go_clear;
      logic       go_rev;
      logic       commit;
      logic       commit_rev;
      logic       set_result;
      logic [1:0] result_verdict;
      logic       result_added;
      logic       emit;
   } tfw_cmd_type;

   typedef struct packed {
      logic early;
      logic trusted;
      logic hit;
      logic sweep_done;
   } tfw_status_type;

endpackage

// File: sv/tcp_flow_tracking_firewall_unit.sv
// ----------------------------------------------------------------------------
// TCP flow tracking firewall unit
// Stateful TCP connection tracking with an LRU flow table and APB registers.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   request   start high, busy low       req_* header summary fields
//   result    rsp_valid for one cycle    rsp_verdict, rsp_flow_added
//   config    psel, penable, pwrite      paddr, pwdata, prdata
//
// Frames decided by the header checks skip the table passes. A lookup hit runs a
// lookup and a touch pass; a new flow pair runs a lookup, a forward touch and a
// reverse touch pass. Each table pass reads one entry per cycle from the key and
// recency RAMs. After reset, busy stays high while a pass clears the recency RAM.
// One transaction is in flight at a time; the receiver cannot stall results.
//
module tcp_flow_tracking_firewall_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_meta_room_ok,
   input  logic [15:0] req_frame_len,
   input  logic [15:0] req_ether_type,
   input  logic [3:0]  req_ip_ihl,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_flow_added,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import tfw_pkg::*;

   logic [31:0]    trusted_net_ff;
   logic [31:0]    trusted_mask_ff;
   logic           csr_write;
   tfw_cmd_type    cmd;
   tfw_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trusted_net_ff  <= TRUSTED_NET_RESET;
         trusted_mask_ff <= TRUSTED_MASK_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_TRUSTED_NET:  trusted_net_ff  <= pwdata;
            REG_TRUSTED_MASK: trusted_mask_ff <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TRUSTED_NET:  prdata = trusted_net_ff;
         REG_TRUSTED_MASK: prdata = trusted_mask_ff;
         default:          prdata = '0;
      endcase
   end

   tfw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   tfw_datapath #(
      .DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_meta_room_ok(req_meta_room_ok),
      .req_frame_len   (req_frame_len),
      .req_ether_type  (req_ether_type),
      .req_ip_ihl      (req_ip_ihl),
      .req_ip_protocol (req_ip_protocol),
      .req_src_addr    (req_src_addr),
      .req_dst_addr    (req_dst_addr),
      .req_src_port    (req_src_port),
      .req_dst_port    (req_dst_port),
      .trusted_net     (trusted_net_ff),
      .trusted_mask    (trusted_mask_ff),
      .rsp_valid       (rsp_valid),
      .rsp_verdict     (rsp_verdict),
      .rsp_flow_added  (rsp_flow_added)
   );

   a_single_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_result_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a transaction is still in progress");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_no_sweep_overlap : assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !status.sweep_done)
      else $error("table pass started while another pass is finishing");

endmodule

// File: sv/tfw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tfw_ctrl.sv
// ----------------------------------------------------------------------------
// TCP flow firewall controller
// Sequences the clearing pass, lookup and update sweeps and the result.
// ----------------------------------------------------------------------------
module tfw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tfw_pkg::tfw_status_type status,
   output tfw_pkg::tfw_cmd_type    cmd
);

   import tfw_pkg::*;

   tfw_state_type state_ff;
   tfw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.go       = 1'b1;
            cmd.go_clear = 1'b1;
            state_in     = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.early) begin
               state_in = ST_EMIT;
            end else begin
               cmd.go        = 1'b1;
               cmd.go_search = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.sweep_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.set_result = 1'b1;
            if (status.hit) begin
               cmd.commit         = 1'b1;
               cmd.go             = 1'b1;
               cmd.go_touch       = 1'b1;
               cmd.result_verdict = VERDICT_TX;
               state_in           = ST_TOUCH_LAST;
            end else if (status.trusted) begin
               cmd.commit         = 1'b1;
               cmd.go             = 1'b1;
               cmd.go_touch       = 1'b1;
               cmd.go_search      = 1'b1;
               cmd.go_rev         = 1'b1;
               cmd.result_verdict = VERDICT_TX;
               cmd.result_added   = 1'b1;
               state_in           = ST_TOUCH_FWD;
            end else begin
               cmd.result_verdict = VERDICT_DROP;
               state_in           = ST_EMIT;
            end
         end
         ST_TOUCH_FWD: begin
            if (status.sweep_done) begin
               state_in = ST_COMMIT_REV;
            end
         end
         ST_COMMIT_REV: begin
            cmd.commit     = 1'b1;
            cmd.commit_rev = 1'b1;
            cmd.go         = 1'b1;
            cmd.go_touch   = 1'b1;
            state_in       = ST_TOUCH_LAST;
         end
         ST_TOUCH_LAST: begin
            if (status.sweep_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// File: sv/tfw_datapath.sv
// ----------------------------------------------------------------------------
// TCP flow firewall datapath
// Header checks, flow key RAM, recency RAM and the sweep over the table.
// ----------------------------------------------------------------------------
module tfw_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tfw_pkg::tfw_cmd_type    cmd,
   output tfw_pkg::tfw_status_type status,
   input  logic                    req_meta_room_ok,
   input  logic [15:0]             req_frame_len,
   input  logic [15:0]             req_ether_type,
   input  logic [3:0]              req_ip_ihl,
   input  logic [7:0]              req_ip_protocol,
   input  logic [31:0]             req_src_addr,
   input  logic [31:0]             req_dst_addr,
   input  logic [15:0]             req_src_port,
   input  logic [15:0]             req_dst_port,
   input  logic [31:0]             trusted_net,
   input  logic [31:0]             trusted_mask,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_verdict,
   output logic                    rsp_flow_added
);

   import tfw_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   // Header checks and request capture.
   logic [KEY_W-1:0] key_fwd_ff;
   logic [KEY_W-1:0] key_rev;
   logic             early_ff;
   logic             trusted_ff;
   logic [1:0]       verdict_ff;
   logic             added_ff;
   logic [16:0]      min_tcp_len;
   logic             early_in;
   logic [1:0]       early_verdict;

   assign min_tcp_len = TCP_HDR_BASE + 17'({req_ip_ihl, 2'b00});

   always_comb begin
      early_in      = 1'b1;
      early_verdict = VERDICT_DROP;
      if (!req_meta_room_ok || req_frame_len < ETH_HDR_LEN) begin
         early_verdict = VERDICT_DROP;
      end else if (req_ether_type != ETHERTYPE_IPV4) begin
         early_verdict = VERDICT_PASS;
      end else if (req_frame_len < IP_MIN_FRAME || req_ip_protocol != PROTO_TCP ||
                   req_ip_ihl < IHL_MIN || {1'b0, req_frame_len} < min_tcp_len) begin
         early_verdict = VERDICT_DROP;
      end else begin
         early_in = 1'b0;
      end
   end

   assign key_rev = {key_fwd_ff[63:32], key_fwd_ff[95:64],
                     key_fwd_ff[15:0], key_fwd_ff[31:16]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_fwd_ff <= {req_src_addr, req_dst_addr, req_src_port, req_dst_port};
         early_ff   <= early_in;
         trusted_ff <= ((req_src_addr & trusted_mask) == trusted_net);
         verdict_ff <= early_verdict;
         added_ff   <= 1'b0;
      end else if (cmd.set_result) begin
         verdict_ff <= cmd.result_verdict;
         added_ff   <= cmd.result_added;
      end
   end

   // Sweep sequencing: one address issued per cycle, its data returned in the next cycle.
   logic          run_ff, run_in;
   logic [AW-1:0] issue_ff, issue_in;
   logic          p_vld_ff;
   logic [AW-1:0] p_idx_ff;
   logic          m_touch_ff, m_search_ff, m_clear_ff, m_rev_ff;

   always_comb begin
      run_in   = run_ff;
      issue_in = issue_ff;
      if (cmd.go) begin
         run_in   = 1'b1;
         issue_in = '0;
      end else if (run_ff) begin
         issue_in = issue_ff + AW'(1);
         if (issue_ff == LAST) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         p_vld_ff <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      p_idx_ff <= issue_ff;
      if (cmd.go) begin
         m_touch_ff  <= cmd.go_touch;
         m_search_ff <= cmd.go_search;
         m_clear_ff  <= cmd.go_clear;
         m_rev_ff    <= cmd.go_rev;
      end
   end

   // Table storage.
   logic [KEY_W-1:0] key_rdata;
   logic [AW:0]      st_rdata;
   logic [AW-1:0]    sel_idx;
   logic             sel_valid;
   logic [AW-1:0]    sel_age;
   logic             upd_valid;
   logic [AW-1:0]    upd_age;
   logic             st_we;

   tfw_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (cmd.commit),
      .wr_addr(sel_idx),
      .wr_data(cmd.commit_rev ? key_rev : key_fwd_ff),
      .rd_addr(issue_ff),
      .rd_data(key_rdata)
   );

   tfw_ram #(
      .WIDTH(AW + 1),
      .DEPTH(DEPTH)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(p_idx_ff),
      .wr_data({upd_valid, upd_age}),
      .rd_addr(issue_ff),
      .rd_data(st_rdata)
   );

   // Recency update for the entry in the data stage.
   logic [AW-1:0] t_idx_ff;
   logic          t_valid_ff;
   logic [AW-1:0] t_age_ff;

   always_comb begin
      upd_valid = st_rdata[AW];
      upd_age   = st_rdata[AW-1:0];
      if (m_clear_ff) begin
         upd_valid = 1'b0;
         upd_age   = '0;
      end else if (m_touch_ff) begin
         if (p_idx_ff == t_idx_ff) begin
            upd_valid = 1'b1;
            upd_age   = '0;
         end else if (st_rdata[AW] && (!t_valid_ff || st_rdata[AW-1:0] < t_age_ff)) begin
            upd_age = st_rdata[AW-1:0] + AW'(1);
         end
      end
   end

   assign st_we = p_vld_ff && (m_clear_ff || m_touch_ff);

   // Search: first match, first free slot, oldest entry.
   logic          mf_ff, mf_in, ff_ff, ff_in, xf_ff, xf_in;
   logic [AW-1:0] mi_ff, mi_in, ma_ff, ma_in, fi_ff, fi_in, xi_ff, xi_in, xa_ff, xa_in;
   logic [KEY_W-1:0] search_key;

   assign search_key = m_rev_ff ? key_rev : key_fwd_ff;

   always_comb begin
      mf_in = mf_ff;
      mi_in = mi_ff;
      ma_in = ma_ff;
      ff_in = ff_ff;
      fi_in = fi_ff;
      xf_in = xf_ff;
      xi_in = xi_ff;
      xa_in = xa_ff;
      if (cmd.go) begin
         mf_in = 1'b0;
         ff_in = 1'b0;
         xf_in = 1'b0;
      end else if (p_vld_ff && m_search_ff) begin
         if (!mf_ff && upd_valid && key_rdata == search_key) begin
            mf_in = 1'b1;
            mi_in = p_idx_ff;
            ma_in = upd_age;
         end
         if (!ff_ff && !upd_valid) begin
            ff_in = 1'b1;
            fi_in = p_idx_ff;
         end
         if (upd_valid && (!xf_ff || upd_age > xa_ff)) begin
            xf_in = 1'b1;
            xi_in = p_idx_ff;
            xa_in = upd_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mf_ff <= 1'b0;
         ff_ff <= 1'b0;
         xf_ff <= 1'b0;
      end else begin
         mf_ff <= mf_in;
         ff_ff <= ff_in;
         xf_ff <= xf_in;
      end
   end

   always_ff @(posedge clock) begin
      mi_ff <= mi_in;
      ma_ff <= ma_in;
      fi_ff <= fi_in;
      xi_ff <= xi_in;
      xa_ff <= xa_in;
   end

   always_comb begin
      if (mf_ff) begin
         sel_idx   = mi_ff;
         sel_valid = 1'b1;
         sel_age   = ma_ff;
      end else if (ff_ff) begin
         sel_idx   = fi_ff;
         sel_valid = 1'b0;
         sel_age   = '0;
      end else begin
         sel_idx   = xi_ff;
         sel_valid = 1'b1;
         sel_age   = xa_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         t_idx_ff   <= sel_idx;
         t_valid_ff <= sel_valid;
         t_age_ff   <= sel_age;
      end
   end

   // Result register.
   logic       rsp_valid_ff;
   logic [1:0] rsp_verdict_ff;
   logic       rsp_added_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_added_ff   <= added_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_flow_added = rsp_added_ff;

   assign status.early      = early_ff;
   assign status.trusted    = trusted_ff;
   assign status.hit        = mf_ff;
   assign status.sweep_done = p_vld_ff && (p_idx_ff == LAST);

endmodule

// File: tb/sv/tb_tcp_flow_tracking_firewall_unit.sv
// ----------------------------------------------------------------------------
// TCP flow tracking firewall unit testbench
// Drives header summaries into the firewall, predicts each verdict with a
// software copy of the flow table and its recency ranks, and checks every
// result in order. The run sweeps the trusted network settings over the APB
// port, including the all-trusted and single-address extremes.
// ----------------------------------------------------------------------------
module tb_tcp_flow_tracking_firewall_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tfw_pkg::*;

   localparam int FLOW_SLOTS        = 64;
   localparam int TAIL_CYCLES       = 3 * FLOW_SLOTS + 8;
   localparam int WATCHDOG_LIMIT    = 20 * TAIL_CYCLES;
   localparam int POOL_FLOWS        = 40;
   localparam int ITEMS_PER_SETTING = 320;

   typedef struct packed {
      logic        room;
      logic [15:0] flen;
      logic [15:0] etype;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
   } packet_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       added;
   } verdict_type;

   typedef enum {
      BREAK_ROOM,
      BREAK_SHORT_ETH,
      BREAK_ETHERTYPE,
      BREAK_SHORT_IP,
      BREAK_PROTOCOL,
      BREAK_IHL,
      BREAK_SHORT_TCP
   } defect_type;

   class verdict_tracker;
      logic [31:0] trusted_net;
      logic [31:0] trusted_mask;
      logic [63:0] flow_addrs[FLOW_SLOTS];
      logic [31:0] flow_ports[FLOW_SLOTS];
      bit          flow_live[FLOW_SLOTS];
      int unsigned flow_rank[FLOW_SLOTS];
      verdict_type pending_verdicts[$];
      int          errors;
      int          packets;
      int          transmitted;
      int          hits;
      int          installs;
      int          evictions;
      int          passed;
      int          dropped;

      function new();
         trusted_net  = TRUSTED_NET_RESET;
         trusted_mask = TRUSTED_MASK_RESET;
         foreach (flow_live[i]) begin
            flow_live[i] = 1'b0;
            flow_rank[i] = 0;
         end
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_TRUSTED_NET) begin
            trusted_net = value;
         end else begin
            trusted_mask = value;
         end
      endfunction

      function logic [31:0] register_value(logic idx);
         return (idx == REG_TRUSTED_NET) ? trusted_net : trusted_mask;
      endfunction

      function int flow_slot(logic [63:0] addrs, logic [31:0] ports);
         for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (flow_live[i] && flow_addrs[i] == addrs && flow_ports[i] == ports) begin
               return i;
            end
         end
         return -1;
      endfunction

      // The slot becomes rank 0; entries that were more recent age by one.
      function void make_recent(int slot);
         int unsigned limit;
         limit = flow_live[slot] ? flow_rank[slot] : FLOW_SLOTS;
         for (int j = 0; j < FLOW_SLOTS; j++) begin
            if (j != slot && flow_live[j] && flow_rank[j] < limit) begin
               flow_rank[j]++;
            end
         end
         flow_rank[slot] = 0;
         flow_live[slot] = 1'b1;
      endfunction

      function void install_flow(logic [63:0] addrs, logic [31:0] ports);
         int slot;
         slot = flow_slot(addrs, ports);
         for (int j = 0; j < FLOW_SLOTS && slot < 0; j++) begin
            if (!flow_live[j]) begin
               slot = j;
            end
         end
         if (slot < 0) begin
            slot = 0;
            for (int j = 1; j < FLOW_SLOTS; j++) begin
               if (flow_rank[j] > flow_rank[slot]) begin
                  slot = j;
               end
            end
            evictions++;
         end
         flow_addrs[slot] = addrs;
         flow_ports[slot] = ports;
         make_recent(slot);
      endfunction

      function void predict_verdict(packet_type p);
         verdict_type want;
         logic [63:0] addrs;
         logic [31:0] ports;
         int          slot;
         want.added = 1'b0;
         packets++;
         if (!p.room || p.flen < ETH_HDR_LEN) begin
            want.verdict = VERDICT_DROP;
         end else if (p.etype != ETHERTYPE_IPV4) begin
            want.verdict = VERDICT_PASS;
         end else if (p.flen < IP_MIN_FRAME || p.proto != PROTO_TCP || p.ihl < IHL_MIN ||
                      {1'b0, p.flen} < TCP_HDR_BASE + {11'd0, p.ihl, 2'b00}) begin
            want.verdict = VERDICT_DROP;
         end else begin
            addrs = {p.sa, p.da};
            ports = {p.sp, p.dp};
            slot  = flow_slot(addrs, ports);
            if (slot >= 0) begin
               make_recent(slot);
               want.verdict = VERDICT_TX;
               hits++;
            end else if ((p.sa & trusted_mask) == trusted_net) begin
               install_flow(addrs, ports);
               install_flow({p.da, p.sa}, {p.dp, p.sp});
               want.verdict = VERDICT_TX;
               want.added   = 1'b1;
               installs++;
            end else begin
               want.verdict = VERDICT_DROP;
            end
         end
         if (want.verdict == VERDICT_TX) transmitted++;
         else if (want.verdict == VERDICT_PASS) passed++;
         else dropped++;
         pending_verdicts.push_back(want);
      endfunction

      function void check_verdict(logic [1:0] verdict, logic added);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, verdict %0d flow_added %0d",
                     $time, verdict, added);
            return;
         end
         want = pending_verdicts.pop_front();
         if (verdict !== want.verdict) begin
            errors++;
            $display("%0t: verdict mismatch, expected %0d actual %0d",
                     $time, want.verdict, verdict);
         end
         if (added !== want.added) begin
            errors++;
            $display("%0t: flow_added mismatch, expected %0d actual %0d",
                     $time, want.added, added);
         end
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_meta_room_ok;
   logic [15:0] req_frame_len;
   logic [15:0] req_ether_type;
   logic [3:0]  req_ip_ihl;
   logic [7:0]  req_ip_protocol;
   logic [31:0] req_src_addr;
   logic [31:0] req_dst_addr;
   logic [15:0] req_src_port;
   logic [15:0] req_dst_port;
   logic        rsp_valid;
   logic [1:0]  rsp_verdict;
   logic        rsp_flow_added;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   verdict_tracker sb;
   int          quiet_cycles = 0;
   int          csr_checks = 0;
   int          settings_seen = 1;
   bit          burst = 1'b0;
   logic [31:0] pool_sa[POOL_FLOWS];
   logic [31:0] pool_da[POOL_FLOWS];
   logic [15:0] pool_sp[POOL_FLOWS];
   logic [15:0] pool_dp[POOL_FLOWS];

   tcp_flow_tracking_firewall_unit #(
      .TABLE_DEPTH(FLOW_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_meta_room_ok(req_meta_room_ok),
      .req_frame_len(req_frame_len),
      .req_ether_type(req_ether_type),
      .req_ip_ihl(req_ip_ihl),
      .req_ip_protocol(req_ip_protocol),
      .req_src_addr(req_src_addr),
      .req_dst_addr(req_dst_addr),
      .req_src_port(req_src_port),
      .req_dst_port(req_dst_port),
      .rsp_valid(rsp_valid),
      .rsp_verdict(rsp_verdict),
      .rsp_flow_added(rsp_flow_added),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : watch_requests
      packet_type seen;
      if (!reset && start && !busy) begin
         seen = {req_meta_room_ok, req_frame_len, req_ether_type, req_ip_ihl,
                 req_ip_protocol, req_src_addr, req_dst_addr, req_src_port, req_dst_port};
         sb.predict_verdict(seen);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_verdict(rsp_verdict, rsp_flow_added);
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   function logic [31:0] trusted_source();
      return (sb.trusted_net & sb.trusted_mask) | ($urandom & ~sb.trusted_mask);
   endfunction

   function packet_type tcp_packet(logic [31:0] sa, logic [31:0] da,
                                   logic [15:0] sp, logic [15:0] dp);
      packet_type p;
      int         needed;
      p.room  = 1'b1;
      p.etype = ETHERTYPE_IPV4;
      p.proto = PROTO_TCP;
      p.ihl   = 4'($urandom_range(5, 15));
      needed  = int'(TCP_HDR_BASE) + 4 * int'(p.ihl);
      p.flen  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(needed, 65535))
                                            : 16'($urandom_range(needed, 1514));
      p.sa = sa;
      p.da = da;
      p.sp = sp;
      p.dp = dp;
      return p;
   endfunction

   function packet_type broken_packet();
      packet_type p;
      p = tcp_packet(trusted_source(), $urandom, 16'($urandom), 16'($urandom));
      case (defect_type'($urandom_range(0, 6)))
         BREAK_ROOM: begin
            p.room = 1'b0;
            p.flen = 16'($urandom);
         end
         BREAK_SHORT_ETH: p.flen = 16'($urandom_range(0, 13));
         BREAK_ETHERTYPE: p.etype = ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 65535));
         BREAK_SHORT_IP:  p.flen = 16'($urandom_range(14, 33));
         BREAK_PROTOCOL:  p.proto = PROTO_TCP ^ 8'($urandom_range(1, 255));
         BREAK_IHL:       p.ihl = 4'($urandom_range(0, 4));
         default:         p.flen = 16'($urandom_range(34, 33 + 4 * int'(p.ihl)));
      endcase
      return p;
   endfunction

   function void refill_pool();
      for (int i = 0; i < POOL_FLOWS; i++) begin
         pool_sa[i] = ($urandom_range(0, 3) != 0) ? trusted_source() : $urandom;
         pool_da[i] = $urandom;
         pool_sp[i] = 16'($urandom);
         pool_dp[i] = 16'($urandom);
      end
   endfunction

   // Returns at the edge that accepts the packet, with start still high.
   task send_packet(input packet_type p);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_meta_room_ok <= p.room;
      req_frame_len    <= p.flen;
      req_ether_type   <= p.etype;
      req_ip_ihl       <= p.ihl;
      req_ip_protocol  <= p.proto;
      req_src_addr     <= p.sa;
      req_dst_addr     <= p.da;
      req_src_port     <= p.sp;
      req_dst_port     <= p.dp;
      do @(posedge clock); while (busy);
   endtask

   task wait_for_verdicts();
      start <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0 || busy);
   endtask

   task write_csr(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_register(idx, value);
      @(posedge clock);
   endtask

   task read_csr(input logic idx);
      logic [31:0] want;
      want    = sb.register_value(idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      csr_checks++;
      if (prdata !== want) begin
         sb.errors++;
         $display("%0t: register %0d read mismatch, expected %h actual %h",
                  $time, idx, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task apply_settings(input logic [31:0] net, input logic [31:0] mask);
      wait_for_verdicts();
      write_csr(REG_TRUSTED_NET, net);
      write_csr(REG_TRUSTED_MASK, mask);
      read_csr(REG_TRUSTED_NET);
      read_csr(REG_TRUSTED_MASK);
      refill_pool();
      settings_seen++;
   endtask

   task run_directed();
      packet_type  p;
      logic [31:0] home;
      logic [31:0] remote;
      home   = TRUSTED_NET_RESET | 32'h0000_0021;
      remote = 32'h0A00_0001;
      p = tcp_packet(home, remote, 16'd1024, 16'd80);
      p.room = 1'b0;
      send_packet(p);
      p.room = 1'b1;
      p.flen = 16'd0;
      send_packet(p);
      p.flen = 16'd13;
      send_packet(p);
      p.flen  = 16'd14;
      p.etype = 16'h86DD;
      send_packet(p);
      p.flen  = 16'hFFFF;
      p.etype = 16'hFFFF;
      send_packet(p);
      p = tcp_packet(home, remote, 16'd1024, 16'd80);
      p.flen = 16'd33;
      send_packet(p);
      p = tcp_packet(home, remote, 16'd1024, 16'd80);
      p.proto = 8'd17;
      send_packet(p);
      p.proto = 8'hFF;
      send_packet(p);
      p = tcp_packet(home, remote, 16'd1024, 16'd80);
      p.ihl = 4'd4;
      send_packet(p);
      p.ihl = 4'd0;
      send_packet(p);
      p.ihl  = 4'd15;
      p.flen = 16'd93;
      send_packet(p);
      p.flen = 16'd94;
      send_packet(p);
      send_packet(p);
      send_packet(tcp_packet(remote, home, 16'd80, 16'd1024));
      send_packet(tcp_packet(remote + 32'd1, home, 16'd5000, 16'd22));
      p = tcp_packet(home + 32'd1, home + 32'd1, 16'd7777, 16'd7777);
      send_packet(p);
      send_packet(p);
      p = tcp_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      p.ihl  = 4'd15;
      p.flen = 16'hFFFF;
      send_packet(p);
      p = tcp_packet(32'd0, 32'd0, 16'd0, 16'd0);
      p.ihl  = 4'd5;
      p.flen = 16'd54;
      send_packet(p);
      send_packet(tcp_packet(TRUSTED_NET_RESET | 32'hFF, remote, 16'd443, 16'd443));
      send_packet(tcp_packet(TRUSTED_NET_RESET + 32'h100, remote, 16'd443, 16'd443));
   endtask

   task run_traffic(input int count);
      packet_type   p;
      int           kind;
      int           pick;
      logic [159:0] noise;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 2) wait_for_verdicts();
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            pick = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, POOL_FLOWS - 1);
            if ($urandom_range(0, 1) == 1) begin
               p = tcp_packet(pool_sa[pick], pool_da[pick], pool_sp[pick], pool_dp[pick]);
            end else begin
               p = tcp_packet(pool_da[pick], pool_sa[pick], pool_dp[pick], pool_sp[pick]);
            end
         end else if (kind < 70) begin
            p = tcp_packet(trusted_source(), $urandom, 16'($urandom), 16'($urandom));
         end else if (kind < 78) begin
            p = tcp_packet($urandom, $urandom, 16'($urandom), 16'($urandom));
         end else if (kind < 90) begin
            p = broken_packet();
         end else begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            p     = noise[$bits(packet_type)-1:0];
         end
         send_packet(p);
      end
      burst = 1'b0;
   endtask

   initial begin
      logic [31:0] mask;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_meta_room_ok <= 1'b0;
      req_frame_len    <= '0;
      req_ether_type   <= '0;
      req_ip_ihl       <= '0;
      req_ip_protocol  <= '0;
      req_src_addr     <= '0;
      req_dst_addr     <= '0;
      req_src_port     <= '0;
      req_dst_port     <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      read_csr(REG_TRUSTED_NET);
      read_csr(REG_TRUSTED_MASK);
      refill_pool();
      run_directed();
      run_traffic(ITEMS_PER_SETTING);
      apply_settings(32'h0000_0000, 32'h0000_0000);
      run_traffic(ITEMS_PER_SETTING);
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_traffic(ITEMS_PER_SETTING);
      mask = 32'hFFFF_FFFF << $urandom_range(8, 24);
      apply_settings($urandom & mask, mask);
      run_traffic(ITEMS_PER_SETTING);
      apply_settings(TRUSTED_NET_RESET, TRUSTED_MASK_RESET);
      run_traffic(ITEMS_PER_SETTING);
      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d packets under %0d network settings: %0d sent on (%0d hits).",
               sb.packets, settings_seen, sb.transmitted, sb.hits);
      $display("Installed %0d flow pairs, %0d evictions; %0d passed, %0d dropped, %0d reads.",
               sb.installs, sb.evictions, sb.passed, sb.dropped, csr_checks);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
